// ----- hdl/tcp_nat_mapping_table_macros.svh -----
// Assertion macros shared by the NAT table modules.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TCP_NAT_MAPPING_TABLE_MACROS_SVH
`define TCP_NAT_MAPPING_TABLE_MACROS_SVH

// checked only outside reset
`define TNAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TNAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tnat_pkg.sv -----
// Package for the TCP NAT mapping table: codes, defaults, entry word and
// controller/datapath interface structs. No dependencies.
`default_nettype none

package tnat_pkg;

  localparam int DEF_ENTRIES    = 256;
  localparam int DEF_PORT_SPACE = 65536;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PCNT_W     = 17;
  localparam int REM_W      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_EXT_IP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO   = 2'd3;

  localparam logic [31:0] RST_EXT_IP     = 32'd0;
  localparam logic [15:0] RST_PORT_FIRST = 16'd12345;
  localparam logic [15:0] RST_PORT_LIMIT = 16'd23456;
  localparam logic [15:0] RST_IDLE_TMO   = 16'd60;

  localparam logic [2:0] ST_XLATED  = 3'd0;
  localparam logic [2:0] ST_NO_MAP  = 3'd1;
  localparam logic [2:0] ST_NO_PORT = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  localparam logic [1:0] CLOSE_OPEN  = 2'd0;
  localparam logic [1:0] CLOSE_FIN   = 2'd1;
  localparam logic [1:0] CLOSE_ACKED = 2'd2;

  localparam logic [REM_W-1:0] REM_MAX = 9'd511;

  typedef struct packed {
    logic [31:0] inner_ip;
    logic [15:0] inner_port;
    logic [15:0] outer_port;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [1:0]  inner_close;
    logic [1:0]  outer_close;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic escan;
    logic pscan;
    logic commit;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic escan_done;
    logic pscan_done;
    logic hit;
    logic got;
    logic slot;
    logic mode;
    logic dir;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/tcp_nat_mapping_table.sv -----
// TCP NAPT mapping table. One transaction in, one result out, one at a time.
// After reset the port bitmap is cleared (in_stall high, config writes still
// taken). A tick or an inbound miss scans every entry, one entry read per
// cycle from the entry RAM, then drains the registered read and loads the
// result; a hit stops the scan once the hitting entry is evaluated and adds a
// commit step; an outbound miss adds the port scan, trying ports from
// port_first upward in the port bitmap RAM, and a commit step when an entry
// is made. A stalled result holds the load. A new transaction can be taken as
// soon as the result is in the output register, even if it is not yet taken.
// Depends on tnat_pkg, tnat_ctrl, tnat_dp, tnat_ram.
`default_nettype none

module tcp_nat_mapping_table #(
  parameter int ENTRIES    = tnat_pkg::DEF_ENTRIES,
  parameter int PORT_SPACE = tnat_pkg::DEF_PORT_SPACE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [tnat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tnat_pkg::CFG_DATA_W-1:0] cfg_data,
  // packet / tick transactions
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic                            in_direction,
  input  logic [31:0]                     in_src_ip,
  input  logic [15:0]                     in_src_port,
  input  logic [31:0]                     in_dst_ip,
  input  logic [15:0]                     in_dst_port,
  input  logic                            in_flag_fin,
  input  logic                            in_flag_ack,
  input  logic                            in_flag_rst,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [31:0]                     out_new_ip,
  output logic [15:0]                     out_xlat_port,
  output logic [tnat_pkg::REM_W-1:0]      out_removed_count
);
  import tnat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tnat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // tables, scanners and result register
  tnat_dp #(.ENTRIES(ENTRIES), .PORT_SPACE(PORT_SPACE)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mode(in_mode), .in_direction(in_direction),
    .in_src_ip(in_src_ip), .in_src_port(in_src_port),
    .in_dst_ip(in_dst_ip), .in_dst_port(in_dst_port),
    .in_flag_fin(in_flag_fin), .in_flag_ack(in_flag_ack), .in_flag_rst(in_flag_rst),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_new_ip(out_new_ip),
    .out_xlat_port(out_xlat_port), .out_removed_count(out_removed_count),
    .cmd(cmd), .sts(sts)
  );

endmodule

`default_nettype wire

// ----- hdl/tnat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tnat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/tnat_ctrl.sv -----
// Sequencer for the NAT table: clear pass, entry scan, port scan, commit, result.
// Depends on tnat_pkg and tcp_nat_mapping_table_macros.svh.
`default_nettype none
`include "tcp_nat_mapping_table_macros.svh"

module tnat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tnat_pkg::sts_t sts,
  output tnat_pkg::cmd_t cmd
);
  import tnat_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ESCAN  = 3'd2;
  localparam logic [2:0] S_PSCAN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ESCAN;
        end
      end
      S_ESCAN: begin
        cmd.escan = 1'b1;
        if (sts.escan_done) begin
          if (sts.mode)      state_nxt = S_DONE;
          else if (sts.hit)  state_nxt = S_COMMIT;
          else if (sts.dir)  state_nxt = S_DONE;
          else               state_nxt = S_PSCAN;
        end
      end
      S_PSCAN: begin
        cmd.pscan = 1'b1;
        if (sts.pscan_done) begin
          state_nxt = (sts.got && sts.slot) ? S_COMMIT : S_DONE;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  `TNAT_ASSERT(a_load_free, cmd.load |-> sts.out_free, "result loaded over a pending one")
  `TNAT_ASSERT(a_clear_once, (state_r != S_CLEAR) |=> (state_r != S_CLEAR), "clear pass re-entered")
  `TNAT_ASSERT(a_pscan_miss, (state_r == S_PSCAN) |-> (!sts.mode && !sts.dir && !sts.hit), "port scan outside outbound miss")
  `TNAT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (state_r == S_CLEAR), "reset does not start clear pass")

endmodule

`default_nettype wire

// ----- hdl/tnat_dp.sv -----
// Datapath for the NAT table: config registers, entry and port RAMs, scanners,
// commit logic and result register. Depends on tnat_pkg, tnat_ram and the macros.
`default_nettype none
`include "tcp_nat_mapping_table_macros.svh"

module tnat_dp #(
  parameter int ENTRIES    = tnat_pkg::DEF_ENTRIES,
  parameter int PORT_SPACE = tnat_pkg::DEF_PORT_SPACE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tnat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tnat_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_mode,
  input  logic                               in_direction,
  input  logic [31:0]                        in_src_ip,
  input  logic [15:0]                        in_src_port,
  input  logic [31:0]                        in_dst_ip,
  input  logic [15:0]                        in_dst_port,
  input  logic                               in_flag_fin,
  input  logic                               in_flag_ack,
  input  logic                               in_flag_rst,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_status,
  output logic [31:0]                        out_new_ip,
  output logic [15:0]                        out_xlat_port,
  output logic [tnat_pkg::REM_W-1:0]         out_removed_count,
  input  tnat_pkg::cmd_t                     cmd,
  output tnat_pkg::sts_t                     sts
);
  import tnat_pkg::*;

  localparam int EW  = $clog2(ENTRIES);
  localparam int EIW = $clog2(ENTRIES + 1);
  localparam int PW  = $clog2(PORT_SPACE);
  localparam logic [EIW-1:0]    E_END  = EIW'(ENTRIES);
  localparam logic [PCNT_W-1:0] PS_TOP = PCNT_W'(PORT_SPACE);
  localparam logic [PW-1:0]     P_LAST = PW'(PORT_SPACE - 1);

  // configuration
  logic [31:0] ext_ip_r;
  logic [15:0] port_first_r, port_limit_r, idle_tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_ip_r     <= RST_EXT_IP;
      port_first_r <= RST_PORT_FIRST;
      port_limit_r <= RST_PORT_LIMIT;
      idle_tmo_r   <= RST_IDLE_TMO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXT_IP:     ext_ip_r     <= cfg_data;
        REG_PORT_FIRST: port_first_r <= cfg_data[15:0];
        REG_PORT_LIMIT: port_limit_r <= cfg_data[15:0];
        REG_IDLE_TMO:   idle_tmo_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        mode_r, dir_r, fin_r, ack_r, rst_r;
  logic [31:0] sip_r, dip_r;
  logic [15:0] sport_r, dport_r;
  logic [31:0] tick_r;

  // scan state
  logic [PW-1:0]     ccnt_r;
  logic [ENTRIES-1:0] valid_r;
  logic [EIW-1:0]    eidx_r;
  logic              ev_r;
  logic [EW-1:0]     ev_idx_r;
  logic              hit_r, slot_r;
  logic [EW-1:0]     hit_idx_r, slot_idx_r;
  entry_t            hit_word_r;
  logic [REM_W-1:0]  removed_r;
  logic [PCNT_W-1:0] pcnt_r;
  logic              pv_r, got_r;
  logic [PW-1:0]     pv_port_r, got_port_r;

  // RAM ports
  entry_t        erd, ewd;
  logic          ewe;
  logic [EW-1:0] ewaddr, eraddr;
  logic          prd, pwd, pwe;
  logic [PW-1:0] pwaddr;

  tnat_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewd), .raddr(eraddr), .rdata(erd)
  );

  tnat_ram #(.WIDTH(1), .DEPTH(PORT_SPACE)) u_port_ram (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwd), .raddr(pcnt_r[PW-1:0]), .rdata(prd)
  );

  // entry scan
  logic        e_issue, ev_valid, m_out, m_in, match, expire, sweep_drop;
  logic [31:0] age;

  assign e_issue = cmd.escan && (eidx_r != E_END) && !hit_r;
  assign eraddr  = eidx_r[EW-1:0];
  assign ev_valid = valid_r[ev_idx_r];
  assign m_out = ev_valid && (erd.inner_ip == sip_r) && (erd.inner_port == sport_r) &&
                 (erd.remote_ip == dip_r) && (erd.remote_port == dport_r);
  assign m_in  = ev_valid && (erd.remote_ip == sip_r) && (erd.remote_port == sport_r) &&
                 (erd.outer_port == dport_r) && (dip_r == ext_ip_r);
  assign match = dir_r ? m_in : m_out;
  assign age   = tick_r - erd.stamp;
  assign expire = ev_valid && ((age > {16'd0, idle_tmo_r}) ||
                  ((erd.inner_close == CLOSE_ACKED) && (erd.outer_close == CLOSE_ACKED)));
  assign sweep_drop = ev_r && mode_r && expire;

  // port scan
  logic [PCNT_W-1:0] lim17, top;
  logic              p_issue;

  assign lim17   = {1'b0, port_limit_r};
  assign top     = (lim17 < PS_TOP) ? lim17 : PS_TOP;
  assign p_issue = cmd.pscan && (pcnt_r < top) && !got_r;

  // commit word
  entry_t base, cw;
  logic   hit_drop_ok;

  always_comb begin
    if (hit_r) begin
      base = hit_word_r;
    end else begin
      base.inner_ip    = sip_r;
      base.inner_port  = sport_r;
      base.outer_port  = 16'(got_port_r);
      base.remote_ip   = dip_r;
      base.remote_port = dport_r;
      base.inner_close = CLOSE_OPEN;
      base.outer_close = CLOSE_OPEN;
      base.stamp       = tick_r;
    end
    cw       = base;
    cw.stamp = tick_r;
    if (dir_r) begin
      if (fin_r) cw.outer_close = CLOSE_FIN;
      if ((base.inner_close == CLOSE_FIN) && ack_r) cw.inner_close = CLOSE_ACKED;
    end else begin
      if (fin_r) cw.inner_close = CLOSE_FIN;
      if ((base.outer_close == CLOSE_FIN) && ack_r) cw.outer_close = CLOSE_ACKED;
    end
  end

  assign ewe    = cmd.commit;
  assign ewaddr = hit_r ? hit_idx_r : slot_idx_r;
  assign ewd    = cw;
  assign hit_drop_ok = ({1'b0, hit_word_r.outer_port} < PS_TOP);

  // port bitmap write port
  always_comb begin
    pwe    = 1'b0;
    pwaddr = ccnt_r;
    pwd    = 1'b0;
    if (cmd.clr) begin
      pwe = 1'b1;
    end else if (sweep_drop) begin
      pwe    = ({1'b0, erd.outer_port} < PS_TOP);
      pwaddr = erd.outer_port[PW-1:0];
    end else if (cmd.commit) begin
      if (hit_r) begin
        pwe    = rst_r && hit_drop_ok;
        pwaddr = hit_word_r.outer_port[PW-1:0];
      end else begin
        pwe    = !rst_r;
        pwaddr = got_port_r;
        pwd    = 1'b1;
      end
    end
  end

  // sequential state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r    <= '0;
      valid_r   <= '0;
      tick_r    <= '0;
      mode_r    <= 1'b0;
      dir_r     <= 1'b0;
      eidx_r    <= '0;
      ev_r      <= 1'b0;
      hit_r     <= 1'b0;
      slot_r    <= 1'b0;
      removed_r <= '0;
      pv_r      <= 1'b0;
      got_r     <= 1'b0;
      pcnt_r    <= '0;
    end else begin
      if (cmd.clr) ccnt_r <= PW'(ccnt_r + 1'b1);

      if (cmd.accept) begin
        mode_r    <= in_mode;
        dir_r     <= in_direction;
        sip_r     <= in_src_ip;
        sport_r   <= in_src_port;
        dip_r     <= in_dst_ip;
        dport_r   <= in_dst_port;
        fin_r     <= in_flag_fin;
        ack_r     <= in_flag_ack;
        rst_r     <= in_flag_rst;
        if (in_mode) tick_r <= tick_r + 32'd1;
        eidx_r    <= '0;
        ev_r      <= 1'b0;
        hit_r     <= 1'b0;
        slot_r    <= 1'b0;
        removed_r <= '0;
        pv_r      <= 1'b0;
        got_r     <= 1'b0;
        pcnt_r    <= {1'b0, port_first_r};
      end else begin
        // entry scan: issue one read a cycle, evaluate the one before
        ev_r <= e_issue;
        if (e_issue) begin
          ev_idx_r <= eidx_r[EW-1:0];
          eidx_r   <= EIW'(eidx_r + 1'b1);
          if (!mode_r && !slot_r && !valid_r[eidx_r[EW-1:0]]) begin
            slot_r     <= 1'b1;
            slot_idx_r <= eidx_r[EW-1:0];
          end
        end
        if (ev_r && !mode_r && match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= ev_idx_r;
          hit_word_r <= erd;
        end
        if (sweep_drop) begin
          valid_r[ev_idx_r] <= 1'b0;
          if (removed_r != REM_MAX) removed_r <= REM_W'(removed_r + 1'b1);
        end

        // port scan
        pv_r <= p_issue;
        if (p_issue) begin
          pv_port_r <= pcnt_r[PW-1:0];
          pcnt_r    <= PCNT_W'(pcnt_r + 1'b1);
        end
        if (pv_r && !prd && !got_r) begin
          got_r      <= 1'b1;
          got_port_r <= pv_port_r;
        end

        if (cmd.commit) begin
          if (hit_r && rst_r)        valid_r[hit_idx_r]  <= 1'b0;
          else if (!hit_r && !rst_r) valid_r[slot_idx_r] <= 1'b1;
        end
      end
    end
  end

  // result register
  logic        out_valid_r, xlated;
  logic [2:0]  status_sel, out_status_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_port_r;
  logic [REM_W-1:0] out_rem_r;

  assign xlated = hit_r || (got_r && slot_r);

  always_comb begin
    if (mode_r)      status_sel = ST_TICK;
    else if (xlated) status_sel = ST_XLATED;
    else if (dir_r)  status_sel = ST_NO_MAP;
    else if (!got_r) status_sel = ST_NO_PORT;
    else             status_sel = ST_FULL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_sel;
      out_rem_r    <= mode_r ? removed_r : '0;
      if (!mode_r && xlated) begin
        out_ip_r   <= dir_r ? hit_word_r.inner_ip : ext_ip_r;
        out_port_r <= dir_r ? hit_word_r.inner_port :
                      (hit_r ? hit_word_r.outer_port : 16'(got_port_r));
      end else begin
        out_ip_r   <= '0;
        out_port_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_ip        = out_ip_r;
  assign out_xlat_port     = out_port_r;
  assign out_removed_count = out_rem_r;

  assign sts.clr_done   = (ccnt_r == P_LAST);
  assign sts.escan_done = ((eidx_r == E_END) || hit_r) && !ev_r;
  assign sts.pscan_done = (!(pcnt_r < top) || got_r) && !pv_r;
  assign sts.hit        = hit_r;
  assign sts.got        = got_r;
  assign sts.slot       = slot_r;
  assign sts.mode       = mode_r;
  assign sts.dir        = dir_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  `TNAT_ASSERT(a_commit_target, cmd.commit |-> xlated, "commit without a target entry")
  `TNAT_ASSERT(a_port_outbound, $rose(got_r) |-> (!hit_r && !dir_r && !mode_r), "port taken outside outbound miss")
  `TNAT_ASSERT(a_load_drained, cmd.load |-> !(pv_r || ev_r), "result loaded with scan in flight")

endmodule

`default_nettype wire
